// ----- src/tsg_pkg.sv -----
// Package: shared types, register codes and reset values for the gesture classifier.
`default_nettype none

package tsg_pkg;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_TOUCH    = 2'd0,
		KIND_SLIP     = 2'd1,
		KIND_TOO_FAST = 2'd2
	} kind_t;

	// Configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_SLIP_DISTANCE = 2'd0;
	localparam cfg_idx_t CFG_TOUCH_GAP_US  = 2'd1;
	localparam cfg_idx_t CFG_HOLD_MIN_US   = 2'd2;

	// Register reset values
	localparam logic [11:0] SLIP_DISTANCE_RST = 12'd30;
	localparam logic [31:0] TOUCH_GAP_US_RST  = 32'd200000;
	localparam logic [31:0] HOLD_MIN_US_RST   = 32'd40000;

	// Depth of the queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [11:0] slip_distance;
		logic [31:0] touch_gap_us;
		logic [31:0] hold_min_us;
	} cfg_t;

	// One finished gesture as handed from front to back
	typedef struct packed {
		logic        too_fast;
		logic [11:0] begin_x;
		logic [11:0] begin_y;
		logic [11:0] end_x;
		logic [11:0] end_y;
		logic [31:0] time_us;
	} rec_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// ----- src/tsg_ifs.sv -----
// Interfaces: sample input, result output and configuration write channels.
`default_nettype none

interface tsg_sample_if;
	logic        valid;
	logic        ready;
	logic [11:0] pos_x;
	logic [11:0] pos_y;
	logic [9:0]  pressure;
	logic [31:0] time_us;

	modport source (output valid, pos_x, pos_y, pressure, time_us, input ready);
	modport sink   (input valid, pos_x, pos_y, pressure, time_us, output ready);
endinterface

interface tsg_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         event_kind;
	logic [11:0]        begin_x;
	logic [11:0]        begin_y;
	logic [11:0]        end_x;
	logic [11:0]        end_y;
	logic signed [12:0] delta_x;
	logic signed [12:0] delta_y;
	logic [31:0]        event_time;

	modport source (output valid, event_kind, begin_x, begin_y, end_x, end_y,
		delta_x, delta_y, event_time, input ready);
	modport sink   (input valid, event_kind, begin_x, begin_y, end_x, end_y,
		delta_x, delta_y, event_time, output ready);
endinterface

interface tsg_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/tsg_front.sv -----
// Front: accepts samples, tracks the gesture and decides when a release ends it.
`default_nettype none

module tsg_front import tsg_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tsg_sample_if.sink   sample,
	input  wire cfg_t    cfg,
	input  wire q_stat_t qstat,
	output logic         push,
	output rec_t         rec
);

	logic        in_gesture_q;
	logic        too_fast_q;
	logic [11:0] start_x_q;
	logic [11:0] start_y_q;
	logic [31:0] start_time_q;
	logic [31:0] last_event_time_q;

	logic        starting;
	logic        accept;
	logic        eff_too_fast;
	logic [31:0] eff_start_time;
	logic [31:0] gap_diff;
	logic [31:0] hold_diff;
	logic        ends;

	// Take a sample whenever the queue has room
	assign sample.ready = !qstat.full;
	assign accept       = sample.valid && sample.ready;
	assign starting     = !in_gesture_q;

	// Gesture start values, taken from the sample itself when idle
	assign gap_diff       = sample.time_us - last_event_time_q;
	assign eff_too_fast   = starting ? (gap_diff < cfg.touch_gap_us) : too_fast_q;
	assign eff_start_time = starting ? sample.time_us : start_time_q;
	assign hold_diff      = sample.time_us - eff_start_time;

	// A release counts when too fast or held long enough
	assign ends = (sample.pressure == '0) &&
		(eff_too_fast || !(hold_diff < cfg.hold_min_us));

	assign push = accept && ends;

	always_comb begin
		rec.too_fast = eff_too_fast;
		rec.begin_x  = starting ? sample.pos_x : start_x_q;
		rec.begin_y  = starting ? sample.pos_y : start_y_q;
		rec.end_x    = sample.pos_x;
		rec.end_y    = sample.pos_y;
		rec.time_us  = sample.time_us;
	end

	// Hold gesture state; clear it when a gesture ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_gesture_q      <= 1'b0;
			too_fast_q        <= 1'b0;
			start_x_q         <= '0;
			start_y_q         <= '0;
			start_time_q      <= '0;
			last_event_time_q <= '0;
		end else if (accept) begin
			if (ends) begin
				in_gesture_q      <= 1'b0;
				too_fast_q        <= 1'b0;
				last_event_time_q <= sample.time_us;
			end else if (starting) begin
				in_gesture_q <= 1'b1;
				too_fast_q   <= eff_too_fast;
				start_x_q    <= sample.pos_x;
				start_y_q    <= sample.pos_y;
				start_time_q <= sample.time_us;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/tsg_queue.sv -----
// Queue: short FIFO of finished gestures between front and back.
`default_nettype none

module tsg_queue import tsg_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire rec_t push_rec,
	input  wire logic pop,
	output rec_t      head,
	output q_stat_t   qstat
);

	rec_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign qstat.full  = (count_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/tsg_back.sv -----
// Back: classifies a finished gesture and holds it in the output register.
`default_nettype none

module tsg_back import tsg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [11:0] slip_distance,
	input  wire rec_t        head,
	input  wire q_stat_t     qstat,
	output logic             pop,
	tsg_result_if.source     result
);

	logic               valid_s1;
	kind_t              kind_s1;
	rec_t               rec_s1;
	logic signed [12:0] dx_s1;
	logic signed [12:0] dy_s1;

	logic [11:0]        adx;
	logic [11:0]        ady;
	logic               slip;
	kind_t              kind;
	logic signed [12:0] dx;
	logic signed [12:0] dy;

	// Load when the output register is free or being drained
	assign pop = !qstat.empty && (!valid_s1 || result.ready);

	// Classify the queue head
	assign adx  = (head.end_x >= head.begin_x) ? head.end_x - head.begin_x
		: head.begin_x - head.end_x;
	assign ady  = (head.end_y >= head.begin_y) ? head.end_y - head.begin_y
		: head.begin_y - head.end_y;
	assign slip = (adx > slip_distance) || (ady > slip_distance);

	always_comb begin
		dx = '0;
		dy = '0;
		if (head.too_fast) begin
			kind = KIND_TOO_FAST;
		end else if (slip) begin
			kind = KIND_SLIP;
			dx   = $signed({1'b0, head.end_x}) - $signed({1'b0, head.begin_x});
			dy   = $signed({1'b0, head.end_y}) - $signed({1'b0, head.begin_y});
		end else begin
			kind = KIND_TOUCH;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= 1'b1;
		end else if (result.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1 <= kind;
			rec_s1  <= head;
			dx_s1   <= dx;
			dy_s1   <= dy;
		end
	end

	assign result.valid      = valid_s1;
	assign result.event_kind = kind_s1;
	assign result.begin_x    = rec_s1.begin_x;
	assign result.begin_y    = rec_s1.begin_y;
	assign result.end_x      = rec_s1.end_x;
	assign result.end_y      = rec_s1.end_y;
	assign result.delta_x    = dx_s1;
	assign result.delta_y    = dy_s1;
	assign result.event_time = rec_s1.time_us;

endmodule

`default_nettype wire

// ----- src/tap_swipe_gesture_classifier_core.sv -----
// Top level: configuration registers, front, queue and back of the gesture classifier.
//
//  channel  direction  payload
//  sample   in         pos_x, pos_y, pressure, time_us
//  result   out        event_kind, begin_x, begin_y, end_x, end_y, delta_x, delta_y, event_time
//  cfg      in         index, data
//
// One sample is taken per cycle while the two-entry gesture queue has room.
// A releasing sample is written into the gesture queue when taken, then enters the result register once that is free.
// The front decides gesture ends in the cycle of acceptance; the back classifies.
// arst_n clears gesture state, the queue and the output valid; registers return to reset values.
// A stalled result first fills the queue, then drops sample ready.
`default_nettype none

module tap_swipe_gesture_classifier_core import tsg_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tsg_sample_if.sink   sample,
	tsg_result_if.source result,
	tsg_cfg_if.sink      cfg
);

	cfg_t    cfg_q;
	logic    push;
	rec_t    push_rec;
	logic    pop;
	rec_t    head;
	q_stat_t qstat;

	assign cfg.ready = 1'b1;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slip_distance <= SLIP_DISTANCE_RST;
			cfg_q.touch_gap_us  <= TOUCH_GAP_US_RST;
			cfg_q.hold_min_us   <= HOLD_MIN_US_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_SLIP_DISTANCE: cfg_q.slip_distance <= cfg.data[11:0];
				CFG_TOUCH_GAP_US:  cfg_q.touch_gap_us  <= cfg.data;
				CFG_HOLD_MIN_US:   cfg_q.hold_min_us   <= cfg.data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	tsg_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.cfg    (cfg_q),
		.qstat  (qstat),
		.push   (push),
		.rec    (push_rec)
	);

	tsg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	tsg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.slip_distance (cfg_q.slip_distance),
		.head          (head),
		.qstat         (qstat),
		.pop           (pop),
		.result        (result)
	);

	// Only an accepted release may push a gesture
	a_push_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (sample.valid && sample.ready && sample.pressure == '0))
		else $error("gesture pushed without an accepted release");

	// Never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("gesture queue overflow");

	// A pop always lands in the output register next cycle
	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> result.valid)
		else $error("popped gesture not presented");

	// Deltas are zero unless the gesture is a slip
	a_delta_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.event_kind != KIND_SLIP) |->
		(result.delta_x == '0 && result.delta_y == '0))
		else $error("nonzero delta on a non-slip result");

endmodule

`default_nettype wire
